// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the pid controller rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pid_aw_pkg.sv -----
// package for the pid controller with anti-windup: constants, register map,
// microcode step and control word types, the control store and a saturation helper
package pid_aw_pkg;

	// loop time step and integrator start value, q16.16
	localparam int DT_Q16           = 6554;
	localparam int INITIAL_INTEGRAL = 0;

	// derivative divide: fixed reciprocal of the time step and its shift,
	// sized so the estimate is at most one below the true quotient
	localparam longint DT_SCALED = longint'(DT_Q16) << 16;
	localparam int     DIV_SH    = $clog2(DT_SCALED) - 1;
	localparam longint DIV_RCP   = (longint'(1) << (16 + DIV_SH)) / longint'(DT_Q16);

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_GAIN_P    = 3'd1;
	localparam logic [2:0] REG_GAIN_I    = 3'd2;
	localparam logic [2:0] REG_GAIN_D    = 3'd3;
	localparam logic [2:0] REG_DRIVE_MAX = 3'd4;
	localparam logic [2:0] REG_DRIVE_MIN = 3'd5;
	localparam logic [2:0] REG_DEAD_BAND = 3'd6;
	localparam logic [2:0] REG_INT_LIMIT = 3'd7;

	// program steps
	typedef enum logic [3:0] {
		ST_IDLE  = 4'd0,
		ST_ERR   = 4'd1,
		ST_PREP  = 4'd2,
		ST_INTEG = 4'd3,
		ST_DQ    = 4'd4,
		ST_DFIN  = 4'd5,
		ST_ACCP  = 4'd6,
		ST_ACCI  = 4'd7,
		ST_ACCD  = 4'd8,
		ST_OUT   = 4'd9
	} step_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ERR,
		OP_PREP,
		OP_INTEG,
		OP_DQ,
		OP_DFIN,
		OP_ACCP,
		OP_ACCI,
		OP_ACCD,
		OP_OUT
	} op_t;

	// multiplier operand selection
	typedef enum logic [2:0] {
		M_NONE,
		M_DT,
		M_RCP,
		M_QDT,
		M_P,
		M_I,
		M_D
	} msel_t;

	// sequencing
	typedef enum logic [1:0] {
		J_NEXT,
		J_IN,
		J_OUT
	} jmp_t;

	typedef struct packed {
		op_t   op;
		msel_t msel;
		jmp_t  jmp;
		step_t tgt;
	} uword_t;

	// control store
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = '{op: OP_NOP, msel: M_NONE, jmp: J_NEXT, tgt: ST_IDLE};
		unique case (s)
			ST_IDLE:  w = '{op: OP_NOP,   msel: M_NONE, jmp: J_IN,   tgt: ST_OUT};
			ST_ERR:   w = '{op: OP_ERR,   msel: M_NONE, jmp: J_NEXT, tgt: ST_IDLE};
			ST_PREP:  w = '{op: OP_PREP,  msel: M_DT,   jmp: J_NEXT, tgt: ST_IDLE};
			ST_INTEG: w = '{op: OP_INTEG, msel: M_RCP,  jmp: J_NEXT, tgt: ST_IDLE};
			ST_DQ:    w = '{op: OP_DQ,    msel: M_QDT,  jmp: J_NEXT, tgt: ST_IDLE};
			ST_DFIN:  w = '{op: OP_DFIN,  msel: M_P,    jmp: J_NEXT, tgt: ST_IDLE};
			ST_ACCP:  w = '{op: OP_ACCP,  msel: M_I,    jmp: J_NEXT, tgt: ST_IDLE};
			ST_ACCI:  w = '{op: OP_ACCI,  msel: M_D,    jmp: J_NEXT, tgt: ST_IDLE};
			ST_ACCD:  w = '{op: OP_ACCD,  msel: M_NONE, jmp: J_NEXT, tgt: ST_IDLE};
			ST_OUT:   w = '{op: OP_OUT,   msel: M_NONE, jmp: J_OUT,  tgt: ST_IDLE};
			default:  w = '{op: OP_NOP,   msel: M_NONE, jmp: J_OUT,  tgt: ST_IDLE};
		endcase
		return w;
	endfunction

	// saturate a 50-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
		logic signed [31:0] r;
		if (x[49:31] == {19{x[49]}})
			r = x[31:0];
		else if (x[49])
			r = 32'sh8000_0000;
		else
			r = 32'sh7fff_ffff;
		return r;
	endfunction

endpackage

// ----- hw/rtl/pid_controller_antiwindup.sv -----
// pid controller with anti-windup, q16.16 datapath run by a microcoded sequencer
// depends on pid_aw_pkg and assert_macros.svh
//
// An enabled item runs every step of the program before the output step loads the
// result register; a disabled item skips from idle to the output step. The
// derivative divide by the time step is a multiply by a fixed reciprocal and a
// one-step remainder correction, and that multiply, the integral step and the
// three gain products share one 33x33 multiplier, one product a step. Input stall
// is high whenever the sequencer is off its idle step; a finished result waits in
// the output register and the next item is taken meanwhile, and a new result that
// finds the register still full holds on the output step until it drains.
// Configuration sits on an apb port, register i at byte address 4*i; the user must
// write it only while the block is idle, which the block itself does not enforce.
`include "assert_macros.svh"

module pid_controller_antiwindup (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] target,
	input  logic signed [31:0] measured,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] drive,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import pid_aw_pkg::*;

	localparam logic [32:0]        DSAT_LIM = 33'(DT_Q16) << 15;
	localparam logic signed [32:0] DT_S     = 33'(DT_Q16);
	localparam logic signed [32:0] RCP_S    = 33'(DIV_RCP);

	// configuration registers
	logic               en_q;
	logic signed [31:0] gp_q, gi_q, gd_q, dmax_q, dmin_q, ilim_q;
	logic [30:0]        db_q;

	// controller state
	logic signed [31:0] acc_q, lerr_q, ldrv_q;

	// sequencer
	step_t              step_q, step_nxt;
	uword_t             uw;
	logic               dis_q, ov_q;

	// datapath
	logic signed [31:0] t_q, m_q, err_q, deriv_q, drive_q;
	logic signed [63:0] prod_q;
	logic signed [49:0] sum_q;
	logic [32:0]        adiff_q;
	logic [31:0]        qest_q;
	logic               dneg_q, dsat_q, cond_q;

	logic               in_acc, out_free, wr_en;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [32:0] err_wide, diff;
	logic [32:0]        adiff;
	logic [31:0]        mag;
	logic [31:0]        qest_w, q_fix;
	logic [48:0]        rem_fix;
	logic signed [47:0] prod_sh;
	logic signed [31:0] acc_sat, acc_new, drv_sat, drv_clamp;

	assign pready   = 1'b1;
	assign wr_en    = psel & penable & pwrite;
	assign in_stall = (step_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~ov_q | ~out_stall;
	assign out_valid = ov_q;
	assign drive    = drive_q;
	assign uw       = ucode(step_q);

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b1;
			gp_q   <= '0;
			gi_q   <= '0;
			gd_q   <= '0;
			dmax_q <= 32'sd65536;
			dmin_q <= '0;
			db_q   <= '0;
			ilim_q <= 32'sh7fff_ffff;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_ENABLE:    en_q   <= pwdata[0];
				REG_GAIN_P:    gp_q   <= pwdata;
				REG_GAIN_I:    gi_q   <= pwdata;
				REG_GAIN_D:    gd_q   <= pwdata;
				REG_DRIVE_MAX: dmax_q <= pwdata;
				REG_DRIVE_MIN: dmin_q <= pwdata;
				REG_DEAD_BAND: db_q   <= pwdata[30:0];
				REG_INT_LIMIT: ilim_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (paddr[4:2])
			REG_ENABLE:    prdata = {31'd0, en_q};
			REG_GAIN_P:    prdata = gp_q;
			REG_GAIN_I:    prdata = gi_q;
			REG_GAIN_D:    prdata = gd_q;
			REG_DRIVE_MAX: prdata = dmax_q;
			REG_DRIVE_MIN: prdata = dmin_q;
			REG_DEAD_BAND: prdata = {1'b0, db_q};
			REG_INT_LIMIT: prdata = ilim_q;
			default:       prdata = '0;
		endcase
	end

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

	// next step from the control word
	always_comb begin
		step_nxt = step_q;
		unique case (uw.jmp)
			J_NEXT: step_nxt = step_t'(4'(step_q) + 4'd1);
			J_IN: begin
				if (in_acc)
					step_nxt = en_q ? step_t'(4'(step_q) + 4'd1) : uw.tgt;
			end
			J_OUT: begin
				if (out_free)
					step_nxt = uw.tgt;
			end
			default: step_nxt = ST_IDLE;
		endcase
	end

	// quotient estimate from the reciprocal product
	assign qest_w = prod_q[DIV_SH +: 32];

	// shared multiplier operands
	always_comb begin
		mul_a = 33'(err_q);
		mul_b = DT_S;
		case (uw.msel)
			M_DT:  begin mul_a = 33'(err_q);            mul_b = DT_S; end
			M_RCP: begin mul_a = $signed(adiff_q);      mul_b = RCP_S; end
			M_QDT: begin mul_a = $signed({1'b0, qest_w}); mul_b = DT_S; end
			M_P:   begin mul_a = 33'(gp_q);             mul_b = 33'(err_q); end
			M_I:   begin mul_a = 33'(gi_q);             mul_b = 33'(acc_q); end
			M_D:   begin mul_a = 33'(gd_q);             mul_b = 33'(deriv_q); end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// datapath arithmetic
	always_comb begin
		err_wide  = 33'(t_q) - 33'(m_q);
		diff      = 33'(err_q) - 33'(lerr_q);
		adiff     = diff[32] ? 33'(-diff) : 33'(diff);
		mag       = err_q[31] ? 32'(-err_q) : 32'(err_q);
		prod_sh   = prod_q[63:16];
		acc_sat   = sat32(50'(acc_q) + 50'(prod_sh));
		acc_new   = (acc_sat > ilim_q) ? ilim_q : acc_sat;
		// remainder left by the estimate, one step of correction
		rem_fix   = {adiff_q, 16'd0} - prod_q[48:0];
		q_fix     = qest_q + {31'd0, (rem_fix >= 49'(DT_Q16))};
		drv_sat   = sat32(sum_q);
		if (drv_sat > dmax_q)
			drv_clamp = dmax_q;
		else if (drv_sat < dmin_q)
			drv_clamp = dmin_q;
		else
			drv_clamp = drv_sat;
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			t_q <= target;
			m_q <= measured;
		end
		if (uw.msel != M_NONE)
			prod_q <= mul_p[63:0];
		case (uw.op)
			OP_ERR: err_q <= sat32(50'(err_wide));
			OP_PREP: begin
				cond_q  <= ({1'b0, db_q} < mag) && (ldrv_q < dmax_q);
				dneg_q  <= diff[32];
				dsat_q  <= (adiff >= DSAT_LIM);
				adiff_q <= adiff;
			end
			OP_DQ: qest_q <= qest_w;
			OP_DFIN: begin
				if (dsat_q)
					deriv_q <= dneg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
				else
					deriv_q <= dneg_q ? -$signed(q_fix) : $signed(q_fix);
			end
			OP_ACCP: sum_q <= 50'(prod_sh);
			OP_ACCI: sum_q <= sum_q + 50'(prod_sh);
			OP_ACCD: sum_q <= sum_q + 50'(prod_sh);
			OP_OUT: begin
				if (out_free)
					drive_q <= dis_q ? dmin_q : drv_clamp;
			end
			default: ;
		endcase
	end

	// control and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 32'(INITIAL_INTEGRAL);
			lerr_q <= '0;
			ldrv_q <= '0;
			dis_q  <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (in_acc)
				dis_q <= ~en_q;
			if (uw.op == OP_INTEG && cond_q)
				acc_q <= acc_new;
			// result beat enters the output register; a held beat leaves when not stalled
			if (uw.op == OP_OUT && out_free) begin
				ov_q <= 1'b1;
				if (!dis_q) begin
					ldrv_q <= drv_clamp;
					lerr_q <= err_q;
				end
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// checks on the sequencer, the output hold and the integrator clamp
	`ASSERT_NEXT(a_accept_branch, in_acc, step_q == ST_ERR || step_q == ST_OUT, "bad step after accept")
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(drive), "stalled beat changed")
	`ASSERT_NEXT(a_int_clamp, step_q == ST_INTEG && cond_q, acc_q <= ilim_q, "integral above limit")

endmodule

// ----- tb/sv/tb_pid_controller_antiwindup.sv -----
`timescale 1ns / 100ps
// testbench for pid_controller_antiwindup: directed and random sample beats
// checked against a q16.16 controller model held in this file
// depends on pid_aw_pkg and the pid_controller_antiwindup rtl
module tb_pid_controller_antiwindup;
	import pid_aw_pkg::*;

	localparam logic signed [31:0] ONE     = 32'sh0001_0000;
	localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
	localparam int                 NO_BEAT_LIMIT = 5000;
	localparam int                 RAND_PHASES   = 10;
	localparam int                 PHASE_BEATS   = 145;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] target   = '0;
	logic signed [31:0] measured = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] drive;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [4:0]         paddr   = '0;
	logic [31:0]        pwdata  = '0;
	logic [31:0]        prdata;
	logic               pready;

	// register copies and controller state
	logic               cfg_enable;
	logic signed [31:0] cfg_gain_p, cfg_gain_i, cfg_gain_d;
	logic signed [31:0] cfg_drive_max, cfg_drive_min, cfg_int_limit;
	longint             cfg_dead_band;
	logic signed [31:0] st_integral, st_last_error, st_last_drive;

	logic signed [31:0] pending_drive[$];
	logic signed [31:0] drive_want;
	logic               no_idle = 1'b0;
	int                 mismatches = 0;
	int                 no_beat_cycles = 0;

	pid_controller_antiwindup uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .target(target), .measured(measured),
		.out_valid(out_valid), .out_stall(out_stall), .drive(drive),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic signed [31:0] clip32(input longint x);
		if (x > longint'(Q_MAX))
			return Q_MAX;
		if (x < longint'(Q_MIN))
			return Q_MIN;
		return x[31:0];
	endfunction

	// expected drive for one sample, advancing the controller state
	function automatic logic signed [31:0] next_drive(input logic signed [31:0] tgt,
			input logic signed [31:0] meas);
		longint             e, mag, sum;
		logic signed [31:0] err, acc, deriv, drv;
		if (!cfg_enable)
			return cfg_drive_min;
		err = clip32(longint'(tgt) - longint'(meas));
		e = err;
		mag = (e < 0) ? -e : e;
		// integrate outside the dead band unless the last drive sat at the top
		if (mag > cfg_dead_band && st_last_drive < cfg_drive_max) begin
			acc = clip32(longint'(st_integral) + ((e * DT_Q16) >>> 16));
			if (acc > cfg_int_limit)
				acc = cfg_int_limit;
			st_integral = acc;
		end
		deriv = clip32(((e - longint'(st_last_error)) * 65536) / DT_Q16);
		sum = ((longint'(cfg_gain_p) * e) >>> 16)
			+ ((longint'(cfg_gain_i) * longint'(st_integral)) >>> 16)
			+ ((longint'(cfg_gain_d) * longint'(deriv)) >>> 16);
		drv = clip32(sum);
		// upper limit is checked first, then the lower
		if (drv > cfg_drive_max)
			drv = cfg_drive_max;
		else if (drv < cfg_drive_min)
			drv = cfg_drive_min;
		st_last_drive = drv;
		st_last_error = err;
		return drv;
	endfunction

	task automatic reset_model;
		cfg_enable    = 1'b1;
		cfg_gain_p    = '0;
		cfg_gain_i    = '0;
		cfg_gain_d    = '0;
		cfg_drive_max = ONE;
		cfg_drive_min = '0;
		cfg_dead_band = 0;
		cfg_int_limit = Q_MAX;
		st_integral   = INITIAL_INTEGRAL;
		st_last_error = '0;
		st_last_drive = '0;
	endtask

	task automatic report_mismatch(input string what, input logic signed [31:0] want,
			input logic signed [31:0] got);
		$display("mismatch on %s: expected %0d got %0d at %0t", what, want, got, $time);
		mismatches++;
	endtask

	// apb write: setup then access, register takes the value on pready
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ENABLE:    cfg_enable    = val[0];
			REG_GAIN_P:    cfg_gain_p    = val;
			REG_GAIN_I:    cfg_gain_i    = val;
			REG_GAIN_D:    cfg_gain_d    = val;
			REG_DRIVE_MAX: cfg_drive_max = val;
			REG_DRIVE_MIN: cfg_drive_min = val;
			REG_DEAD_BAND: cfg_dead_band = longint'(val[30:0]);
			REG_INT_LIMIT: cfg_int_limit = val;
			default: ;
		endcase
	endtask

	// one sample beat, with a random gap ahead of it
	task automatic send_sample(input logic signed [31:0] tgt, input logic signed [31:0] meas);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		target   <= tgt;
		measured <= meas;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_drive.push_back(next_drive(tgt, meas));
	endtask

	// stop sending and wait for every drive beat still owed
	task automatic settle;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_drive.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_q(input int unsigned spread);
		logic signed [31:0] r;
		case ($urandom_range(0, 9))
			0:       r = Q_MIN;
			1:       r = Q_MAX;
			2:       r = '0;
			3, 4, 5: r = $urandom;
			default: r = clip32(longint'($urandom_range(0, 2 * spread)) - longint'(spread));
		endcase
		return r;
	endfunction

	task automatic test_reset_defaults;
		send_sample(ONE, '0);
		send_sample('0, ONE);
		settle;
	endtask

	// proportional path, error saturation both ways
	task automatic test_proportional;
		reg_write(REG_GAIN_P, ONE);
		reg_write(REG_DRIVE_MAX, Q_MAX);
		reg_write(REG_DRIVE_MIN, Q_MIN);
		send_sample(Q_MAX, Q_MIN);
		send_sample(Q_MIN, Q_MAX);
		send_sample('0, '0);
		send_sample(3 * ONE, ONE);
		send_sample(-32'sd5, 32'sd7);
		settle;
		reg_write(REG_GAIN_P, Q_MIN);
		send_sample(ONE, '0);
		settle;
	endtask

	// dead band, integral clamp and an integral left above a lowered limit
	// until the next step
	task automatic test_integral;
		reg_write(REG_GAIN_P, '0);
		reg_write(REG_GAIN_I, ONE);
		reg_write(REG_DEAD_BAND, ONE / 2);
		reg_write(REG_DRIVE_MAX, 4 * ONE);
		reg_write(REG_DRIVE_MIN, -4 * ONE);
		reg_write(REG_INT_LIMIT, 2 * ONE);
		send_sample(ONE / 4, '0);
		send_sample(10 * ONE, '0);
		send_sample(10 * ONE, '0);
		send_sample(10 * ONE, '0);
		settle;
		reg_write(REG_INT_LIMIT, -ONE);
		reg_write(REG_DRIVE_MAX, Q_MAX);
		send_sample('0, ONE / 4);
		send_sample('0, 10 * ONE);
		settle;
	endtask

	task automatic test_derivative;
		reg_write(REG_GAIN_I, '0);
		reg_write(REG_GAIN_D, ONE / 16);
		reg_write(REG_DRIVE_MIN, Q_MIN);
		send_sample(ONE, '0);
		send_sample(Q_MAX, Q_MIN);
		send_sample(Q_MIN, Q_MAX);
		send_sample('0, '0);
		settle;
	endtask

	// drive_min above drive_max
	task automatic test_crossed_limits;
		reg_write(REG_GAIN_D, '0);
		reg_write(REG_GAIN_P, ONE);
		reg_write(REG_DRIVE_MAX, -ONE);
		reg_write(REG_DRIVE_MIN, ONE);
		send_sample(5 * ONE, '0);
		send_sample('0, '0);
		send_sample(-5 * ONE, '0);
		settle;
	endtask

	// disabled answers drive_min and keeps state
	task automatic test_disabled;
		reg_write(REG_DRIVE_MAX, 8 * ONE);
		reg_write(REG_DRIVE_MIN, 32'sd3);
		reg_write(REG_GAIN_I, ONE);
		reg_write(REG_ENABLE, 32'hffff_fffe);
		send_sample(Q_MAX, Q_MIN);
		send_sample(ONE, '0);
		settle;
		reg_write(REG_ENABLE, 32'h0000_0001);
		send_sample(ONE, '0);
		settle;
	endtask

	// fresh register set for one random phase, with full-scale extremes
	task automatic rand_config(input int ph);
		logic signed [31:0] a, b;
		logic [31:0]        db;
		a = rand_q(1 << 20);
		b = rand_q(1 << 20);
		db = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 1 << 17);
		reg_write(REG_ENABLE, ($urandom & 32'hffff_fffe) | {31'd0, ($urandom_range(0, 7) != 0)});
		case (ph)
			1: begin
				reg_write(REG_GAIN_P, Q_MAX);
				reg_write(REG_GAIN_I, Q_MAX);
				reg_write(REG_GAIN_D, Q_MAX);
				reg_write(REG_DRIVE_MAX, Q_MAX);
				reg_write(REG_DRIVE_MIN, Q_MIN);
				reg_write(REG_DEAD_BAND, 32'hffff_ffff);
				reg_write(REG_INT_LIMIT, Q_MAX);
			end
			2: begin
				reg_write(REG_GAIN_P, Q_MIN);
				reg_write(REG_GAIN_I, Q_MIN);
				reg_write(REG_GAIN_D, Q_MIN);
				reg_write(REG_DRIVE_MAX, Q_MIN);
				reg_write(REG_DRIVE_MIN, Q_MAX);
				reg_write(REG_DEAD_BAND, 32'h8000_0000);
				reg_write(REG_INT_LIMIT, Q_MIN);
			end
			default: begin
				reg_write(REG_GAIN_P, rand_q(1 << 18));
				reg_write(REG_GAIN_I, rand_q(1 << 18));
				reg_write(REG_GAIN_D, rand_q(1 << 14));
				// mostly ordered limits, sometimes crossed
				if ((a > b) == ($urandom_range(0, 4) != 0)) begin
					reg_write(REG_DRIVE_MAX, a);
					reg_write(REG_DRIVE_MIN, b);
				end else begin
					reg_write(REG_DRIVE_MAX, b);
					reg_write(REG_DRIVE_MIN, a);
				end
				reg_write(REG_DEAD_BAND, db);
				reg_write(REG_INT_LIMIT, rand_q(1 << 22));
			end
		endcase
	endtask

	// setpoint held for a stretch, measurement tracking it with noise
	task automatic test_random_phases;
		logic signed [31:0] setpoint, meas;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			rand_config(ph);
			setpoint = rand_q(1 << 22);
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if (k % 29 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 15) == 0)
					setpoint = rand_q(1 << 22);
				if ($urandom_range(0, 3) == 0) begin
					send_sample(rand_q(1 << 24), rand_q(1 << 24));
				end else begin
					meas = clip32(longint'(setpoint)
						+ longint'($urandom_range(0, 1 << 19)) - longint'(1 << 18));
					send_sample(setpoint, meas);
				end
			end
			settle;
		end
		no_idle = 1'b0;
	endtask

	// result side stall, drawn afresh for every drive beat
	initial begin
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 17);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid && !out_stall))
				@(posedge clk);
		end
	end

	// compare each drive beat with the oldest owed value
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_drive.size() == 0) begin
				report_mismatch("unexpected drive beat", '0, drive);
			end else begin
				drive_want = pending_drive.pop_front();
				if (drive !== drive_want)
					report_mismatch("drive", drive_want, drive);
			end
		end
	end

	// watchdog on cycles with no beat and no register write
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				no_beat_cycles <= 0;
			else
				no_beat_cycles <= no_beat_cycles + 1;
			if (no_beat_cycles >= NO_BEAT_LIMIT) begin
				$display("tb_pid_controller_antiwindup: errors");
				$finish;
			end
		end
	end

	initial begin
		reset_model;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults;
		test_proportional;
		test_integral;
		test_derivative;
		test_crossed_limits;
		test_disabled;
		test_random_phases;
		settle;
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("tb_pid_controller_antiwindup: clean");
		else
			$display("tb_pid_controller_antiwindup: errors");
		$finish;
	end

endmodule
